// ===== src/aisf_pkg.sv =====
// ----------------------------------------------------------------------------
// aisf_pkg
// Shared types and constants for the AIS transmit framer.
// ----------------------------------------------------------------------------
package aisf_pkg;

	localparam int unsigned TRAIN_W = 5;
	localparam logic [TRAIN_W-1:0] TRAIN_MAX = 5'd16;
	localparam logic [TRAIN_W-1:0] TRAIN_RESET = 5'd16;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'h8408;  // 0x1021 bit-reversed

	localparam logic [2:0] STUFF_PRE = 3'd4;           // fifth one in a row stuffs
	localparam logic [7:0] FLAG_LSB_FIRST = 8'h7E;
	localparam logic [4:0] FLAG_LAST = 5'd7;
	localparam logic [4:0] BYTE_BITS = 5'd8;
	localparam logic [4:0] FCS_BITS = 5'd16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic line_level;
		logic frame_end;
		logic last_of_run;
	} res_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               first;
		logic [TRAIN_W-1:0] train_n;
		logic [7:0]         data;
		logic               last;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRAIN,
		PH_OPEN,
		PH_DATA,
		PH_FCS,
		PH_CLOSE
	} phase_t;

endpackage

// ===== src/aisf_fifo.sv =====
// ----------------------------------------------------------------------------
// aisf_fifo
// Small register FIFO with fall-through read data.
// ----------------------------------------------------------------------------
module aisf_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/aisf_front.sv =====
// ----------------------------------------------------------------------------
// aisf_front
// Accepts requests, tracks frame boundaries and tags each byte for the back end.
// ----------------------------------------------------------------------------
module aisf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aisf_pkg::TRAIN_W-1:0]    cfg_data,
	input  logic                            push,
	input  aisf_pkg::req_t                  request,
	input  logic                            cmd_full,
	output logic                            cmd_push,
	output aisf_pkg::cmd_t                  cmd
);
	import aisf_pkg::*;

	logic [TRAIN_W-1:0] train_len_q;
	logic               in_frame_q;

	assign cfg_ready = 1'b1;
	assign cmd_push  = push && !cmd_full;

	always_comb begin
		cmd.first   = !in_frame_q;
		cmd.train_n = (train_len_q > TRAIN_MAX) ? TRAIN_MAX : train_len_q;
		cmd.data    = request.data_byte;
		cmd.last    = request.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_len_q <= TRAIN_RESET;
			in_frame_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				train_len_q <= cfg_data;
			end
			if (cmd_push) begin
				in_frame_q <= !request.last_byte;
			end
		end
	end

endmodule

// ===== src/aisf_back.sv =====
// ----------------------------------------------------------------------------
// aisf_back
// Bit serializer: training, flags, stuffed payload with CRC, FCS, NRZI coding.
// ----------------------------------------------------------------------------
module aisf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  aisf_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic           out_full,
	output logic           out_push,
	output aisf_pkg::res_t out_item
);
	import aisf_pkg::*;

	phase_t                phase_q;
	phase_t                phase_d;
	logic [4:0]            cnt_q;
	logic [TRAIN_W-1:0]    train_n_q;
	logic [15:0]           sreg_q;
	logic [15:0]           crc_q;
	logic [15:0]           crc_d;
	logic [2:0]            ones_q;
	logic                  line_q;
	logic                  last_q;
	logic                  stuff_q;

	logic fire;
	logic bit_v;
	logic seg_done;
	logic stuff_new;
	logic run_end;

	assign fire = (phase_q != PH_IDLE) && !out_full;

	// current bit and end-of-segment decode
	always_comb begin
		bit_v     = 1'b0;
		seg_done  = 1'b0;
		stuff_new = 1'b0;
		unique case (phase_q)
			PH_TRAIN: begin
				bit_v    = cnt_q[0];
				seg_done = (cnt_q == train_n_q - 1'b1);
			end
			PH_OPEN, PH_CLOSE: begin
				bit_v    = FLAG_LSB_FIRST[cnt_q[2:0]];
				seg_done = (cnt_q == FLAG_LAST);
			end
			PH_DATA, PH_FCS: begin
				if (stuff_q) begin
					seg_done = (cnt_q == '0);
				end else begin
					bit_v     = sreg_q[0];
					stuff_new = sreg_q[0] && (ones_q == STUFF_PRE);
					seg_done  = (cnt_q == 5'd1) && !stuff_new;
				end
			end
			default: begin
			end
		endcase
	end

	// run ends after a non-final byte or after the closing flag
	assign run_end = seg_done &&
		(((phase_q == PH_DATA) && !last_q) || (phase_q == PH_CLOSE));

	// outputs
	always_comb begin
		out_push             = fire;
		out_item.line_level  = bit_v ? line_q : !line_q;
		out_item.frame_end   = (phase_q == PH_CLOSE) && seg_done;
		out_item.last_of_run = run_end;
		cmd_pop              = !cmd_empty && ((phase_q == PH_IDLE) || (fire && run_end));
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (cmd_pop) begin
			if (!cmd.first) begin
				phase_d = PH_DATA;
			end else if (cmd.train_n == '0) begin
				phase_d = PH_OPEN;
			end else begin
				phase_d = PH_TRAIN;
			end
		end else if (fire && seg_done) begin
			unique case (phase_q)
				PH_TRAIN: phase_d = PH_OPEN;
				PH_OPEN:  phase_d = PH_DATA;
				PH_DATA:  phase_d = last_q ? PH_FCS : PH_IDLE;
				PH_FCS:   phase_d = PH_CLOSE;
				PH_CLOSE: phase_d = PH_IDLE;
				default:  phase_d = PH_IDLE;
			endcase
		end
	end

	// reflected CRC-16 step on payload bits only
	always_comb begin
		crc_d = crc_q;
		if ((phase_q == PH_DATA) && !stuff_q) begin
			crc_d = (crc_q[0] ^ sreg_q[0]) ? ((crc_q >> 1) ^ CRC_POLY_REFL) : (crc_q >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			train_n_q <= '0;
			sreg_q    <= '0;
			crc_q     <= CRC_INIT;
			ones_q    <= '0;
			line_q    <= 1'b0;
			last_q    <= 1'b0;
			stuff_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				line_q <= out_item.line_level;
				unique case (phase_q)
					PH_TRAIN, PH_OPEN, PH_CLOSE: begin
						cnt_q <= seg_done ? '0 : cnt_q + 1'b1;
					end
					PH_DATA, PH_FCS: begin
						crc_q <= crc_d;
						if (stuff_q) begin
							stuff_q <= 1'b0;
							ones_q  <= '0;
						end else begin
							sreg_q  <= sreg_q >> 1;
							cnt_q   <= cnt_q - 1'b1;
							stuff_q <= stuff_new;
							if (!sreg_q[0] || stuff_new) begin
								ones_q <= '0;
							end else begin
								ones_q <= ones_q + 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
				if (seg_done) begin
					if (phase_q == PH_OPEN) begin
						cnt_q <= BYTE_BITS;
					end else if (phase_q == PH_DATA) begin
						cnt_q  <= FCS_BITS;
						sreg_q <= crc_d ^ CRC_XOROUT;
					end
				end
			end
			if (cmd_pop) begin
				sreg_q    <= {8'h00, cmd.data};
				last_q    <= cmd.last;
				train_n_q <= cmd.train_n;
				stuff_q   <= 1'b0;
				cnt_q     <= cmd.first ? 5'd0 : BYTE_BITS;
				if (cmd.first) begin
					crc_q  <= CRC_INIT;
					ones_q <= '0;
					line_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== src/ais_transmit_framer.sv =====
// ----------------------------------------------------------------------------
// ais_transmit_framer
// HDLC transmit framer with CRC-16/X-25 FCS, bit stuffing and NRZI output.
// ----------------------------------------------------------------------------
// Each request is one payload byte plus a last-byte mark; each result is one
// NRZI line bit (a data 0 toggles the line, a 1 holds it). The first byte of
// a frame is preceded by alternating training bits (training_length, capped
// at 16, taken from the register when that byte is accepted) and the 01111110
// opening flag; the line level restarts at 0 for every frame. Payload goes
// out LSB first with a zero stuffed after five ones and feeds the CRC; the
// last byte is followed by the inverted CRC (LSB first, stuffed) and an
// unstuffed closing flag whose final bit carries frame_end. last_of_run marks
// the last bit caused by each request. The back-end serializer emits one line
// bit per cycle unless the result queue is full; a byte in mid-frame is 8 line bits plus
// any stuffed zeros, a first byte adds up to 16 training bits and 8 flag bits, and a
// last byte adds 16 FCS bits, up to 4 stuffed zeros and 8 flag bits. When the
// serializer has gone idle, the cycle in which it loads the next request carries
// no line bit; a request that is already queued is loaded on the last bit of the
// one before it, with no gap. A short
// request queue between the front end and the serializer lets the next byte
// be taken while the current one is still being shifted out, and a small
// result queue absorbs stalls on the pop side. The configuration channel is
// always ready; a write takes effect at the next frame start.
// ----------------------------------------------------------------------------
module ais_transmit_framer #(
	parameter int unsigned CMD_DEPTH = 2,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [aisf_pkg::TRAIN_W-1:0] cfg_data,
	// request side
	input  logic                         push,
	output logic                         full,
	input  aisf_pkg::req_t               request,
	// result side
	output logic                         empty,
	input  logic                         pop,
	output aisf_pkg::res_t               result
);
	import aisf_pkg::*;

	logic cmd_push;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;
	cmd_t cmd_wr;
	cmd_t cmd_rd;

	logic out_push;
	logic out_full;
	res_t out_item;

	assign full = cmd_full;

	// front end: config register, frame tracking, byte classification
	aisf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.request   (request),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_wr)
	);

	// decoupling queue between the two halves
	aisf_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wr),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	// back end: one line bit per cycle while the result queue has room
	aisf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	// result queue toward the consumer
	aisf_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_item),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	// serializer never takes a command that is not there
	a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command popped from empty queue");

	// serializer never overruns the result queue
	a_res_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into full queue");

	// closing flag always ends the run of its request
	a_frame_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_item.frame_end) |-> out_item.last_of_run)
		else $error("frame end without end of run");

	// after the closing flag the next bit, if any, starts a new frame
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_item.frame_end) |=> !cmd_pop || cmd_rd.first)
		else $error("frame continued after closing flag");
`endif

endmodule
